// File: rtl/rna_pkg.sv
// Shared types, constants and helpers for the radix number to ASCII converter.
package rna_pkg;

  localparam int MAX_DIGITS = 32;
  localparam int VAL_W      = 32;
  localparam int FUNC_W     = 3;
  localparam int CNT_W      = 6;
  localparam int CHAR_W     = 7;
  localparam int DIG_W      = 4;
  localparam int IDX_W      = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int STEP_W     = $clog2(VAL_W);

  localparam logic [CHAR_W-1:0] CHAR_LETTER = 7'd55;
  localparam logic [CHAR_W-1:0] CHAR_DIGIT  = 7'd48;
  localparam logic [CHAR_W-1:0] CHAR_MINUS  = 7'd45;
  localparam logic [CHAR_W-1:0] CHAR_PLUS   = 7'd43;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_BIN  = 3'd0,
    FUNC_OCT  = 3'd1,
    FUNC_DEC  = 3'd2,
    FUNC_HEX  = 3'd3,
    FUNC_SDEC = 3'd4
  } func_t;

  typedef enum logic [1:0] {
    BASE_2  = 2'd0,
    BASE_8  = 2'd1,
    BASE_10 = 2'd2,
    BASE_16 = 2'd3
  } base_t;

  typedef logic [MAX_DIGITS-1:0][DIG_W-1:0] digit_row_t;

  typedef struct packed {
    logic             is_signed;
    logic             neg;
    logic [CNT_W-1:0] n;
  } job_t;

  typedef struct packed {
    logic busy;
    logic full;
  } conv_stat_t;

  typedef struct packed {
    logic active;
  } emit_stat_t;

  function automatic logic [DIG_W:0] base_value(input base_t b);
    logic [DIG_W:0] v;
    case (b)
      BASE_2:  v = 5'd2;
      BASE_8:  v = 5'd8;
      BASE_10: v = 5'd10;
      BASE_16: v = 5'd16;
      default: v = 5'd2;
    endcase
    return v;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIG_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d > 4'd9) begin
      c = CHAR_W'(d) + CHAR_LETTER;
    end else begin
      c = CHAR_W'(d) + CHAR_DIGIT;
    end
    return c;
  endfunction

endpackage

// File: rtl/rna_if.sv
// Valid/ready channel interfaces for the input word and the character word.
interface rna_in_if;
  logic                         valid;
  logic                         ready;
  logic [rna_pkg::FUNC_W-1:0]   func;
  logic [rna_pkg::CNT_W-1:0]    digit_count;
  logic [rna_pkg::VAL_W-1:0]    value;

  modport source(output valid, func, digit_count, value, input ready);
  modport sink(input valid, func, digit_count, value, output ready);
endinterface

interface rna_out_if;
  logic                         valid;
  logic                         ready;
  logic [rna_pkg::CHAR_W-1:0]   char_out;
  logic                         last;

  modport source(output valid, char_out, last, input ready);
  modport sink(input valid, char_out, last, output ready);
endinterface

// File: rtl/rna_cell.sv
// One digit cell: doubles its digit, adds the carry in, reduces modulo the base.
module rna_cell (
  input  logic                      clk,
  input  logic                      clr,
  input  logic                      en,
  input  rna_pkg::base_t            base,
  input  logic                      cin,
  output logic                      cout,
  output logic [rna_pkg::DIG_W-1:0] digit
);

  logic [rna_pkg::DIG_W-1:0] d_r;
  logic [rna_pkg::DIG_W-1:0] d_nxt;
  logic [rna_pkg::DIG_W:0]   bv;
  logic [rna_pkg::DIG_W:0]   wide;
  logic [rna_pkg::DIG_W:0]   red;
  logic                      ge;

  // even base: overflow depends only on the digit, so carries never ripple
  always_comb begin
    bv    = rna_pkg::base_value(base);
    wide  = {d_r, cin};
    ge    = {1'b0, d_r} >= (bv >> 1);
    red   = ge ? (wide - bv) : wide;
    d_nxt = red[rna_pkg::DIG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (clr) begin
      d_r <= '0;
    end else if (en) begin
      d_r <= d_nxt;
    end
  end

  assign cout  = ge;
  assign digit = d_r;

endmodule

// File: rtl/rna_conv.sv
// Converter: feeds the value MSB first into a row of digit cells.
module rna_conv (
  input  logic                  clk,
  input  logic                  rst_n,
  rna_in_if.sink                in_word,
  input  logic                  take,
  output rna_pkg::conv_stat_t   stat,
  output rna_pkg::job_t         job,
  output rna_pkg::digit_row_t   digits
);

  logic                        busy_r, busy_nxt;
  logic                        full_r, full_nxt;
  logic [rna_pkg::STEP_W-1:0]  step_r, step_nxt;
  logic [rna_pkg::VAL_W-1:0]   sh_r, sh_nxt;
  rna_pkg::base_t              base_r, base_nxt;
  rna_pkg::job_t               job_r, job_nxt;

  rna_pkg::func_t              func;
  rna_pkg::base_t              base_sel;
  logic                        job_ok;
  logic                        sgn;
  logic                        neg;
  logic [rna_pkg::CNT_W-1:0]   n_clamp;
  logic [rna_pkg::VAL_W-1:0]   mag;
  logic                        accept;
  logic                        start;
  logic [rna_pkg::MAX_DIGITS:0] carry;

  always_comb begin
    func     = rna_pkg::func_t'(in_word.func);
    base_sel = rna_pkg::BASE_10;
    job_ok   = 1'b0;
    sgn      = 1'b0;
    n_clamp  = (in_word.digit_count > rna_pkg::CNT_W'(rna_pkg::MAX_DIGITS)) ?
               rna_pkg::CNT_W'(rna_pkg::MAX_DIGITS) : in_word.digit_count;
    case (func)
      rna_pkg::FUNC_BIN: begin
        base_sel = rna_pkg::BASE_2;
        job_ok   = n_clamp != '0;
      end
      rna_pkg::FUNC_OCT: begin
        base_sel = rna_pkg::BASE_8;
        job_ok   = n_clamp != '0;
      end
      rna_pkg::FUNC_DEC: begin
        base_sel = rna_pkg::BASE_10;
        job_ok   = n_clamp != '0;
      end
      rna_pkg::FUNC_HEX: begin
        base_sel = rna_pkg::BASE_16;
        job_ok   = n_clamp != '0;
      end
      rna_pkg::FUNC_SDEC: begin
        base_sel = rna_pkg::BASE_10;
        job_ok   = 1'b1;
        sgn      = 1'b1;
      end
      default: begin
        job_ok = 1'b0;
      end
    endcase
    neg = sgn && in_word.value[rna_pkg::VAL_W-1];
    mag = neg ? (rna_pkg::VAL_W'(0) - in_word.value) : in_word.value;
  end

  assign in_word.ready = !busy_r && (!full_r || take);
  assign accept        = in_word.valid && in_word.ready;
  // unknown modes and empty unsigned words are consumed without output
  assign start         = accept && job_ok;

  always_comb begin
    busy_nxt = busy_r;
    full_nxt = full_r;
    step_nxt = step_r;
    sh_nxt   = sh_r;
    base_nxt = base_r;
    job_nxt  = job_r;
    if (take) begin
      full_nxt = 1'b0;
    end
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      sh_nxt   = mag;
      base_nxt = base_sel;
      job_nxt  = '{is_signed: sgn, neg: neg, n: n_clamp};
    end else if (busy_r) begin
      sh_nxt   = sh_r << 1;
      step_nxt = step_r + 1'b1;
      if (step_r == rna_pkg::STEP_W'(rna_pkg::VAL_W - 1)) begin
        busy_nxt = 1'b0;
        full_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      full_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      full_r <= full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    sh_r   <= sh_nxt;
    base_r <= base_nxt;
    job_r  <= job_nxt;
  end

  assign carry[0] = sh_r[rna_pkg::VAL_W-1];

  for (genvar k = 0; k < rna_pkg::MAX_DIGITS; k++) begin : g_cell
    rna_cell u_cell (
      .clk   (clk),
      .clr   (start),
      .en    (busy_r),
      .base  (base_r),
      .cin   (carry[k]),
      .cout  (carry[k+1]),
      .digit (digits[k])
    );
  end

  assign stat = '{busy: busy_r, full: full_r};
  assign job  = job_r;

endmodule

// File: rtl/rna_emit.sv
// Emitter: holds a finished digit row and sends it out one character per cycle while the receiver is ready.
module rna_emit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 full,
  input  rna_pkg::job_t        job,
  input  rna_pkg::digit_row_t  digits,
  output logic                 take,
  output rna_pkg::emit_stat_t  stat,
  rna_out_if.source            out_word
);

  logic                        active_r, active_nxt;
  logic                        sign_r, sign_nxt;
  logic                        none_r, none_nxt;
  logic                        neg_r, neg_nxt;
  logic [rna_pkg::IDX_W-1:0]   pos_r, pos_nxt;
  rna_pkg::digit_row_t         digs_r, digs_nxt;
  logic                        ov_r, ov_nxt;
  logic [rna_pkg::CHAR_W-1:0]  oc_r, oc_nxt;
  logic                        ol_r, ol_nxt;

  logic                        adv;
  logic [rna_pkg::CHAR_W-1:0]  ch;
  logic                        lst;

  assign take = full && !active_r;
  assign adv  = active_r && (!ov_r || out_word.ready);

  always_comb begin
    if (sign_r) begin
      ch  = neg_r ? rna_pkg::CHAR_MINUS : rna_pkg::CHAR_PLUS;
      lst = none_r;
    end else begin
      ch  = rna_pkg::digit_char(digs_r[pos_r]);
      lst = pos_r == '0;
    end
  end

  always_comb begin
    active_nxt = active_r;
    sign_nxt   = sign_r;
    none_nxt   = none_r;
    neg_nxt    = neg_r;
    pos_nxt    = pos_r;
    digs_nxt   = digs_r;
    ov_nxt     = ov_r;
    oc_nxt     = oc_r;
    ol_nxt     = ol_r;
    if (take) begin
      active_nxt = 1'b1;
      sign_nxt   = job.is_signed;
      none_nxt   = job.n == '0;
      neg_nxt    = job.neg;
      pos_nxt    = rna_pkg::IDX_W'(job.n - 1'b1);
      digs_nxt   = digits;
    end
    if (adv) begin
      ov_nxt = 1'b1;
      oc_nxt = ch;
      ol_nxt = lst;
      if (sign_r) begin
        sign_nxt = 1'b0;
        if (none_r) begin
          active_nxt = 1'b0;
        end
      end else if (pos_r == '0) begin
        active_nxt = 1'b0;
      end else begin
        pos_nxt = pos_r - 1'b1;
      end
    end else if (out_word.ready) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      active_r <= active_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sign_r <= sign_nxt;
    none_r <= none_nxt;
    neg_r  <= neg_nxt;
    pos_r  <= pos_nxt;
    digs_r <= digs_nxt;
    oc_r   <= oc_nxt;
    ol_r   <= ol_nxt;
  end

  assign out_word.valid    = ov_r;
  assign out_word.char_out = oc_r;
  assign out_word.last     = ol_r;
  assign stat              = '{active: active_r};

endmodule

// File: rtl/radix_number_to_ascii.sv
// Top level of the radix number to ASCII converter.
//
// in_word carries a mode (func), a digit count and a 32-bit value; out_word
// returns one ASCII character per word, most significant digit first, with
// last set on the final character. Signed decimal mode sends '+' or '-'
// before the digits. Counts above 32 act as 32; unknown modes and unsigned
// words with a zero count are consumed and produce nothing.
// The converter shifts the value one bit per cycle into a row of 32 digit
// cells. While a finished row is being sent out, the next word is already
// converting; a new word is taken only when the converter is idle and any
// finished row it holds is being taken by the emitter.
// A stalled receiver holds the character in the output register; the
// emitter and then the converter fill up and in_word.ready drops.
// Synchronous reset empties both stages; no word is in flight afterwards.
module radix_number_to_ascii (
  input  logic        clk,
  input  logic        rst_n,
  rna_in_if.sink      in_word,
  rna_out_if.source   out_word
);

  rna_pkg::conv_stat_t  conv_stat;
  rna_pkg::emit_stat_t  emit_stat;
  rna_pkg::job_t        job;
  rna_pkg::digit_row_t  digits;
  logic                 take;

  rna_conv u_conv (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_word (in_word),
    .take    (take),
    .stat    (conv_stat),
    .job     (job),
    .digits  (digits)
  );

  rna_emit u_emit (
    .clk      (clk),
    .rst_n    (rst_n),
    .full     (conv_stat.full),
    .job      (job),
    .digits   (digits),
    .take     (take),
    .stat     (emit_stat),
    .out_word (out_word)
  );

`ifndef SYNTH
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_word.valid && in_word.ready) |-> !conv_stat.busy)
    else $error("word accepted while converting");

  a_busy_full_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(conv_stat.busy && conv_stat.full))
    else $error("converter busy and full at once");

  a_row_held: assert property (@(posedge clk) disable iff (!rst_n)
    (conv_stat.full && !take) |=> conv_stat.full)
    else $error("finished row lost before hand-off");

  a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> (emit_stat.active && !conv_stat.full) || conv_stat.busy || emit_stat.active)
    else $error("hand-off did not start emitter");
`endif

endmodule

// File: verif/tb.sv
`timescale 1ns / 100ps
// Testbench for radix_number_to_ascii: digit predictor, character scoreboard and drivers.
module tb;
  import rna_pkg::*;

  localparam int LIMIT        = 2_000_000;
  localparam int DRAIN_CYCLES = 40;
  localparam int RAND_WORDS   = 290;

  typedef struct {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } ascii_char_t;

  class ascii_scoreboard;
    ascii_char_t char_q[$];
    int          errors = 0;

    // Expands one accepted word into the characters it should produce.
    function void note_word(logic [FUNC_W-1:0] f, logic [CNT_W-1:0] cnt,
                            logic [VAL_W-1:0] val);
      logic [DIG_W-1:0] digs[MAX_DIGITS];
      logic [VAL_W-1:0] rem;
      logic [DIG_W:0]   base;
      ascii_char_t      c;
      int               n;
      n = (cnt > MAX_DIGITS) ? MAX_DIGITS : int'(cnt);
      rem = val;
      case (f)
        FUNC_BIN: base = 5'd2;
        FUNC_OCT: base = 5'd8;
        FUNC_DEC: base = 5'd10;
        FUNC_HEX: base = 5'd16;
        FUNC_SDEC: begin
          base = 5'd10;
          // -2^31 negates to itself and reads as 2147483648 unsigned
          if (val[VAL_W-1]) rem = -val;
          c.ch = val[VAL_W-1] ? CHAR_MINUS : CHAR_PLUS;
          c.last = (n == 0);
          char_q.push_back(c);
        end
        default: return;
      endcase
      for (int k = 0; k < n; k++) begin
        digs[k] = DIG_W'(rem % base);
        rem = rem / base;
      end
      for (int k = n - 1; k >= 0; k--) begin
        c.ch = (digs[k] > 4'd9) ? CHAR_LETTER + CHAR_W'(digs[k])
                                : CHAR_DIGIT + CHAR_W'(digs[k]);
        c.last = (k == 0);
        char_q.push_back(c);
      end
    endfunction

    function void check_char(logic [CHAR_W-1:0] ch, logic last);
      ascii_char_t e;
      if (char_q.size() == 0) begin
        $error("char_out: no character expected, got %0h last %0b", ch, last);
        errors++;
        return;
      end
      e = char_q.pop_front();
      if (ch !== e.ch) begin
        $error("char_out mismatch: expected %0h actual %0h", e.ch, ch);
        errors++;
      end
      if (last !== e.last) begin
        $error("last mismatch: expected %0b actual %0b", e.last, last);
        errors++;
      end
    endfunction

    function int pending();
      return char_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  bit   quiet = 1'b0;
  int   cycles = 0;

  ascii_scoreboard sb = new();

  rna_in_if  in_ch();
  rna_out_if out_ch();

  radix_number_to_ascii uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_ch),
    .out_word (out_ch)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("FAIL radix_number_to_ascii");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one; none in quiet stretches
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_word(input logic [FUNC_W-1:0] f, input logic [CNT_W-1:0] cnt,
                           input logic [VAL_W-1:0] val);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.func        <= f;
    in_ch.digit_count <= cnt;
    in_ch.value       <= val;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_word(f, cnt, val);
  endtask

  // words with no characters may still be in flight when the queue empties
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_random_word();
    logic [FUNC_W-1:0] f;
    logic [CNT_W-1:0]  cnt;
    logic [VAL_W-1:0]  val;
    int r;
    r = $urandom_range(0, 99);
    f = (r < 6) ? FUNC_W'($urandom_range(5, 7)) : FUNC_W'($urandom_range(0, 4));
    r = $urandom_range(0, 99);
    if (r < 8) cnt = '0;
    else if (r < 15) cnt = CNT_W'($urandom_range(33, 63));
    else if (r < 22) cnt = CNT_W'(MAX_DIGITS);
    else cnt = CNT_W'($urandom_range(1, 14));
    r = $urandom_range(0, 99);
    if (r < 50) val = $urandom();
    else if (r < 70) val = $urandom_range(0, 255);
    else if (r < 80) begin
      case ($urandom_range(0, 3))
        0: val = '0;
        1: val = '1;
        2: val = 32'h8000_0000;
        default: val = 32'h7FFF_FFFF;
      endcase
    end else val = $urandom() >> $urandom_range(0, 31);
    send_word(f, cnt, val);
  endtask

  // receiver: checks each accepted character, then picks the next stall
  initial begin
    int stall;
    stall = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready)
        sb.check_char(out_ch.char_out, out_ch.last);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        stall--;
      end else begin
        out_ch.ready <= 1'b1;
        stall = idle_len();
      end
    end
  end

  initial begin
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.func        <= '0;
    in_ch.digit_count <= '0;
    in_ch.value       <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // extremes, letters, sign handling
    send_word(FUNC_BIN,  6'd32, 32'hFFFF_FFFF);
    send_word(FUNC_BIN,  6'd32, 32'h0000_0000);
    send_word(FUNC_OCT,  6'd11, 32'hFFFF_FFFF);
    send_word(FUNC_DEC,  6'd10, 32'hFFFF_FFFF);
    send_word(FUNC_HEX,  6'd8,  32'hFEDC_BA98);
    send_word(FUNC_HEX,  6'd8,  32'h7654_3210);
    send_word(FUNC_SDEC, 6'd10, 32'h8000_0000);
    send_word(FUNC_SDEC, 6'd10, 32'h7FFF_FFFF);
    send_word(FUNC_SDEC, 6'd1,  32'hFFFF_FFFF);
    send_word(FUNC_SDEC, 6'd3,  32'h0000_0000);
    // narrow count drops high digits
    send_word(FUNC_DEC,  6'd3,  32'd123456);
    send_word(FUNC_HEX,  6'd1,  32'hABCD_EF0F);
    // wide count pads with zeros
    send_word(FUNC_HEX,  6'd32, 32'h0000_001F);
    send_word(FUNC_DEC,  6'd32, 32'd4096);
    // counts past the digit limit clamp
    send_word(FUNC_BIN,  6'd63, 32'hA5A5_5A5A);
    send_word(FUNC_SDEC, 6'd33, 32'hFFFF_FF85);
    // zero count: nothing unsigned, sign alone when signed
    send_word(FUNC_DEC,  6'd0,  32'd77);
    send_word(FUNC_SDEC, 6'd0,  32'd5);
    send_word(FUNC_SDEC, 6'd0,  32'hFFFF_FFFB);
    // unknown modes
    send_word(3'd5, 6'd4, 32'd1234);
    send_word(3'd6, 6'd4, 32'd1234);
    send_word(3'd7, 6'd32, 32'hFFFF_FFFF);
    send_word(FUNC_OCT,  6'd1,  32'd7);

    // hold off until everything has come back
    drain();

    for (int blk = 0; blk < RAND_WORDS / 29; blk++) begin
      quiet = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 3) == 0) drain();
      repeat (29) send_random_word();
    end

    quiet = 1'b1;
    drain();
    if (sb.errors == 0) begin
      $display("PASS radix_number_to_ascii");
    end else begin
      $display("FAIL radix_number_to_ascii");
    end
    $finish;
  end

endmodule

// File: radix_number_to_ascii.f
rtl/rna_pkg.sv
rtl/rna_if.sv
rtl/rna_cell.sv
rtl/rna_conv.sv
rtl/rna_emit.sv
rtl/radix_number_to_ascii.sv
verif/tb.sv
